[rtl/core/cvwm_pkg.sv]
// ----------------------------------------------------------------------------
// cvwm_pkg
// Shared constants and types of the close variant window mask block.
// ----------------------------------------------------------------------------
package cvwm_pkg;

   localparam int MAX_WINDOW_DEF = 16;
   localparam int BASE_W         = 8;
   localparam int WINDOW_W       = 5;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [BASE_W-1:0]   BASE_N       = 8'h4E;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 5'd5;

   // Register indexes, taken from paddr[2]
   localparam logic REG_WINDOW = 1'b0;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   // Contents of one cell of the holding chain
   typedef struct packed {
      logic [BASE_W-1:0] base;
      logic              diff;
      logic              barrier;   // a newer held position starts a chromosome
   } cell_state_type;

   typedef struct packed {
      logic shift;
      logic insert;
      logic mask;
      logic new_start;
   } cell_ctrl_type;

   typedef struct packed {
      logic [BASE_W-1:0] base;
      logic              diff;
   } entry_type;

endpackage

[rtl/core/cvwm_cell.sv]
// ----------------------------------------------------------------------------
// cvwm_cell
// One position of the holding chain: takes its newer neighbour on a shift,
// takes a new position on insert, and is masked to 'N' on a close cluster.
// ----------------------------------------------------------------------------
module cvwm_cell
   import cvwm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cell_ctrl_type  ctrl,
   input  entry_type      entry,
   input  cell_state_type nbr,
   output cell_state_type cell_out
);

   cell_state_type cell_ff;
   cell_state_type cell_in;
   logic           flag_rst_ff;

   always_comb begin
      cell_in = cell_ff;
      if (ctrl.shift) begin
         cell_in = nbr;
      end else begin
         if (ctrl.insert) begin
            cell_in.base    = entry.base;
            cell_in.diff    = entry.diff;
            cell_in.barrier = 1'b0;
         end else begin
            cell_in.barrier = cell_ff.barrier | ctrl.new_start;
         end
         if (ctrl.mask) begin
            cell_in.base = BASE_N;
         end
      end
   end

   // Payload needs no reset; the flag bits are cleared.
   always_ff @(posedge clock) begin
      cell_ff.base <= cell_in.base;
      if (reset) begin
         cell_ff.diff    <= 1'b0;
         cell_ff.barrier <= 1'b0;
      end else begin
         cell_ff.diff    <= cell_in.diff;
         cell_ff.barrier <= cell_in.barrier;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_rst_ff <= 1'b1;
      end else begin
         flag_rst_ff <= 1'b0;
      end
   end

   // A cell just out of reset reports cleared flags on every field but the base.
   always_comb begin
      cell_out         = cell_ff;
      cell_out.diff    = cell_ff.diff & ~flag_rst_ff;
      cell_out.barrier = cell_ff.barrier & ~flag_rst_ff;
   end

endmodule

[rtl/core/close_variant_window_mask.sv]
// ----------------------------------------------------------------------------
// close_variant_window_mask
// Holds recent genome positions in a chain of cells and masks sample bases of
// clusters of close differences before emitting them in order.
// ----------------------------------------------------------------------------
//   Channel   Direction   Contents
//   req_      in          ref_base, sample_base, chrom_start, last_in
//   rsp_      out         base_out, last_out
//   csr_      in/out      window_size at byte address 0
//
// A request is taken while the block is idle, with the look-back and masking
// over all cells done at once; it then releases n held positions, one per
// cycle while the response is not stalled, by shifting the chain (n is 1 in
// the steady state, 0 while the window fills, up to MAX_WINDOW on a flush). New
// requests wait while the chain is emitting. A stalled response holds the
// chain. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module close_variant_window_mask
   import cvwm_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [BASE_W-1:0]     req_ref_base,
   input  logic [BASE_W-1:0]     req_sample_base,
   input  logic                  req_chrom_start,
   input  logic                  req_last_in,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [BASE_W-1:0]     rsp_base_out,
   output logic                  rsp_last_out,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CW = $clog2(MAX_WINDOW + 1);

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         remain_ff, remain_in;
   logic                  flush_ff, flush_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BASE_W-1:0]     rsp_base_ff, rsp_base_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [WINDOW_W-1:0]   window_ff;

   logic [CW-1:0]         w_eff;
   logic                  accept;
   logic                  emit_go;
   logic                  new_diff;
   logic [CW-1:0]         count_new;
   logic [CW-1:0]         n_out;

   logic [MAX_WINDOW-1:0] scope_vec;
   logic [MAX_WINDOW-1:0] dv_vec;
   logic [MAX_WINDOW-1:0] dv_old;
   logic [MAX_WINDOW-1:0] dv_neg;
   logic [MAX_WINDOW-1:0] mask_vec;
   logic                  cluster;

   cell_state_type        cell_q [MAX_WINDOW+1];
   cell_ctrl_type         ctrl_q [MAX_WINDOW];
   entry_type             entry;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_WINDOW) begin
         window_ff <= csr_pwdata[WINDOW_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_WINDOW) ?
                       {{(CSR_DATA_W-WINDOW_W){1'b0}}, window_ff} : '0;

   always_comb begin
      if (window_ff == '0) begin
         w_eff = CW'(1);
      end else if (int'(window_ff) > MAX_WINDOW) begin
         w_eff = CW'(MAX_WINDOW);
      end else begin
         w_eff = CW'(window_ff);
      end
   end

   // ------------------------------------------------------------- look-back
   assign accept   = req_valid && req_ready;
   assign new_diff = (req_ref_base != BASE_N) && (req_sample_base != BASE_N) &&
                     (req_ref_base != req_sample_base);
   assign entry    = '{base: req_sample_base, diff: new_diff};

   // The cells in scope form a contiguous run ending at the new position.
   for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_scope
      always_comb begin
         if (count_ff == CW'(k)) begin
            scope_vec[k] = 1'b1;
            dv_vec[k]    = new_diff;
         end else begin
            scope_vec[k] = (k < int'(count_ff)) &&
                           !(cell_q[k].barrier || req_chrom_start) &&
                           ((int'(count_ff) - k) < int'(w_eff));
            dv_vec[k]    = scope_vec[k] && cell_q[k].diff;
         end
      end
   end

   assign dv_old   = dv_vec & ~(MAX_WINDOW'(1) << count_ff);
   assign cluster  = new_diff && (|dv_old);
   // Setting every bit at and above the lowest differing position in scope.
   assign dv_neg   = ~dv_vec + MAX_WINDOW'(1);
   assign mask_vec = (dv_vec | dv_neg) & scope_vec & {MAX_WINDOW{cluster}};

   assign count_new = count_ff + CW'(1);

   always_comb begin
      if (req_last_in) begin
         n_out = count_new;
      end else if (count_new > w_eff - CW'(1)) begin
         n_out = count_new - (w_eff - CW'(1));
      end else begin
         n_out = '0;
      end
   end

   // ------------------------------------------------------------ cell chain
   assign cell_q[MAX_WINDOW] = '0;

   for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
      assign ctrl_q[k] = '{shift:     emit_go,
                           insert:    accept && (count_ff == CW'(k)),
                           mask:      accept && mask_vec[k],
                           new_start: accept && req_chrom_start};

      cvwm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl_q[k]),
         .entry    (entry),
         .nbr      (cell_q[k+1]),
         .cell_out (cell_q[k])
      );
   end

   // --------------------------------------------------------------- control
   assign emit_go = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_base_ff <= rsp_base_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      flush_in     = flush_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_base_in  = rsp_base_ff;
      rsp_last_in  = rsp_last_ff;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               count_in  = count_new;
               remain_in = n_out;
               flush_in  = req_last_in;
               if (n_out != '0) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               rsp_base_in  = cell_q[0].base;
               rsp_last_in  = flush_ff && (remain_ff == CW'(1));
               count_in     = count_ff - CW'(1);
               remain_in    = remain_ff - CW'(1);
               if (remain_ff == CW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_base_out = rsp_base_ff;
   assign rsp_last_out = rsp_last_ff;

   // ------------------------------------------------------------ assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (int'(count_ff) <= MAX_WINDOW - 1))
      else $error("held count exceeds the chain length");

   a_remain_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (remain_ff != '0 && remain_ff <= count_ff))
      else $error("emission count out of step with held count");

   a_flush_emits: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_in) |=> (state_ff == ST_EMIT && flush_ff))
      else $error("final request did not start a flush");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for close_variant_window_mask
// Drives genome positions through the request channel and checks every masked
// base against an in-bench model of the look-back window or a hand-written
// expectation. A short table of directed rows comes first, then random phases
// at several window settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import cvwm_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = MAX_WINDOW_DEF + 4;
   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_ITEMS   = 50;

   localparam logic [BASE_W-1:0] BASE_A       = "A";
   localparam logic [BASE_W-1:0] BASE_C       = "C";
   localparam logic [BASE_W-1:0] BASE_G       = "G";
   localparam logic [BASE_W-1:0] BASE_T       = "T";
   localparam logic [BASE_W-1:0] BASE_LOWER_N = "n";

   localparam logic [CSR_ADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW, 2'b00};

   typedef enum logic {
      ROW_WINDOW,
      ROW_POSITION
   } row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [BASE_W-1:0]   ref_b;
      logic [BASE_W-1:0]   smp_b;
      logic                start_b;
      logic                last_b;
      logic [WINDOW_W-1:0] window;
      logic                typed;
      logic                typed_one;
      logic [BASE_W-1:0]   typed_base;
      logic                typed_last;
   } stim_row_type;

   typedef struct packed {
      logic [BASE_W-1:0] base;
      logic              last_flag;
   } masked_pos_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [BASE_W-1:0]     req_ref_base = '0;
   logic [BASE_W-1:0]     req_sample_base = '0;
   logic                  req_chrom_start = 1'b0;
   logic                  req_last_in = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [BASE_W-1:0]     rsp_base_out;
   logic                  rsp_last_out;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Travels alongside the request so that the scoreboard knows which rows
   // carry a hand-written expectation.
   logic                  row_typed = 1'b0;
   logic                  row_typed_one = 1'b0;
   logic [BASE_W-1:0]     row_typed_base = '0;
   logic                  row_typed_last = 1'b0;

   logic [WINDOW_W-1:0]   window_reg = WINDOW_RESET;
   logic [BASE_W-1:0]     held_base [MAX_WINDOW_DEF];
   logic                  held_diff [MAX_WINDOW_DEF];
   logic                  held_start [MAX_WINDOW_DEF];
   int                    held_count = 0;

   masked_pos_type        masked_q [$];
   int                    errors = 0;
   int                    cycle_count = 0;
   bit                    quiet = 1'b0;

   close_variant_window_mask dut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Adds one position to the window, masks a close cluster and queues every
   // position that falls out of the window (or all of them on a flush) when recording.
   task automatic advance_window(input logic [BASE_W-1:0] ref_b, smp_b,
                                 input logic start_b, last_b, input bit record);
      int  w, idx, lowest, found, seen, i, j, n, rest;
      bit  diff;
      w = int'(window_reg);
      if (w < 1) w = 1;
      if (w > MAX_WINDOW_DEF) w = MAX_WINDOW_DEF;
      diff = (ref_b != BASE_N) && (smp_b != BASE_N) && (ref_b != smp_b);
      if (held_count > MAX_WINDOW_DEF - 1) held_count = MAX_WINDOW_DEF - 1;
      idx = held_count;
      held_base[idx]  = smp_b;
      held_diff[idx]  = diff;
      held_start[idx] = start_b;
      held_count = idx + 1;
      if (diff) begin
         i = idx;
         lowest = idx;
         found = 0;
         seen = 0;
         while (1'b1) begin
            if (held_diff[i]) begin
               found++;
               lowest = i;
            end
            seen++;
            // The position that starts a chromosome is still examined.
            if (held_start[i] || i == 0 || seen >= w) break;
            i--;
         end
         if (found >= 2) begin
            for (j = lowest; j <= idx; j++) held_base[j] = BASE_N;
         end
      end
      if (last_b) n = held_count;
      else n = (held_count > w - 1) ? held_count - (w - 1) : 0;
      if (record) begin
         for (j = 0; j < n; j++) masked_q.push_back({held_base[j], last_b && (j == n - 1)});
      end
      rest = held_count - n;
      for (j = 0; j < rest; j++) begin
         held_base[j]  = held_base[j + n];
         held_diff[j]  = held_diff[j + n];
         held_start[j] = held_start[j + n];
      end
      held_count = rest;
   endtask

   always @(posedge clock) begin : scoreboard
      masked_pos_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            advance_window(req_ref_base, req_sample_base, req_chrom_start, req_last_in,
                           !row_typed);
            if (row_typed && row_typed_one) masked_q.push_back({row_typed_base, row_typed_last});
         end
         if (rsp_valid && rsp_ready) begin
            if (masked_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual base %h last %b",
                        $time, rsp_base_out, rsp_last_out);
               errors++;
            end else begin
               want = masked_q.pop_front();
               if (rsp_base_out !== want.base) begin
                  $display("%0t: base_out mismatch, expected %h, actual %h",
                           $time, want.base, rsp_base_out);
                  errors++;
               end
               if (rsp_last_out !== want.last_flag) begin
                  $display("%0t: last_out mismatch, expected %b, actual %b",
                           $time, want.last_flag, rsp_last_out);
                  errors++;
               end
            end
         end
      end
   end

   initial begin : receiver
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic stim_row_type position_row(input logic [BASE_W-1:0] r, s,
                                                 input logic c, l);
      stim_row_type row;
      row = '0;
      row.kind = ROW_POSITION;
      row.ref_b = r;
      row.smp_b = s;
      row.start_b = c;
      row.last_b = l;
      return row;
   endfunction

   function automatic stim_row_type checked_row(input logic [BASE_W-1:0] r, s,
                                                input logic c, l, one,
                                                input logic [BASE_W-1:0] b,
                                                input logic lo);
      stim_row_type row;
      row = position_row(r, s, c, l);
      row.typed = 1'b1;
      row.typed_one = one;
      row.typed_base = b;
      row.typed_last = lo;
      return row;
   endfunction

   function automatic stim_row_type window_row(input logic [WINDOW_W-1:0] w);
      stim_row_type row;
      row = '0;
      row.kind = ROW_WINDOW;
      row.window = w;
      return row;
   endfunction

   function automatic logic [BASE_W-1:0] pick_base();
      case ($urandom_range(0, 4))
         0: return BASE_A;
         1: return BASE_C;
         2: return BASE_G;
         3: return BASE_T;
         default: return BASE_N;
      endcase
   endfunction

   // Mostly nucleotide letters so that close clusters form, with some raw
   // bytes mixed in.
   function automatic stim_row_type random_row();
      logic [BASE_W-1:0] r, s;
      int                pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         r = BASE_W'($urandom);
         s = BASE_W'($urandom);
      end else begin
         r = pick_base();
         s = ($urandom_range(0, 99) < 35) ? pick_base() : r;
      end
      return position_row(r, s, $urandom_range(0, 11) == 0, $urandom_range(0, 39) == 0);
   endfunction

   task automatic send_position(input stim_row_type row);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_ref_base    <= row.ref_b;
      req_sample_base <= row.smp_b;
      req_chrom_start <= row.start_b;
      req_last_in     <= row.last_b;
      row_typed       <= row.typed;
      row_typed_one   <= row.typed_one;
      row_typed_base  <= row.typed_base;
      row_typed_last  <= row.typed_last;
      do @(posedge clock); while (!req_ready);
   endtask

   // One extra edge first, so that the request accepted at this edge has
   // already been predicted before the queue is looked at.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (masked_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic read_window(input logic [WINDOW_W-1:0] want);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= WINDOW_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[WINDOW_W-1:0] !== want) begin
         $display("%0t: window_size read mismatch, expected %h, actual %h",
                  $time, want, csr_prdata[WINDOW_W-1:0]);
         errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_window(input logic [WINDOW_W-1:0] value);
      drain();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= WINDOW_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      window_reg = value;
      read_window(value);
   endtask

   initial begin : stimulus
      stim_row_type        directed_rows [$];
      logic [WINDOW_W-1:0] w;
      for (int j = 0; j < MAX_WINDOW_DEF; j++) begin
         held_diff[j] = 1'b0;
         held_start[j] = 1'b0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      read_window(WINDOW_RESET);

      // With the reset window of five, the first four positions stay held.
      directed_rows.push_back(checked_row(BASE_A, BASE_A, 1'b1, 1'b0, 1'b0, '0, 1'b0));
      directed_rows.push_back(checked_row(BASE_A, BASE_C, 1'b0, 1'b0, 1'b0, '0, 1'b0));
      directed_rows.push_back(checked_row(BASE_G, BASE_T, 1'b0, 1'b0, 1'b0, '0, 1'b0));
      directed_rows.push_back(checked_row(BASE_N, BASE_T, 1'b0, 1'b0, 1'b0, '0, 1'b0));
      directed_rows.push_back(position_row(BASE_C, BASE_N, 1'b0, 1'b0));
      // A lowercase n is an ordinary letter, not an unknown base.
      directed_rows.push_back(position_row(BASE_LOWER_N, BASE_A, 1'b1, 1'b0));
      directed_rows.push_back(position_row(BASE_A, BASE_G, 1'b0, 1'b0));
      // The chromosome start between these two differences hides the older one.
      directed_rows.push_back(position_row(BASE_A, BASE_A, 1'b1, 1'b0));
      directed_rows.push_back(position_row(BASE_T, BASE_C, 1'b0, 1'b0));
      directed_rows.push_back(position_row(8'hFF, 8'h00, 1'b0, 1'b1));
      // A window of one passes every position straight through.
      directed_rows.push_back(window_row(5'd1));
      directed_rows.push_back(checked_row(BASE_A, BASE_C, 1'b0, 1'b0, 1'b1, BASE_C, 1'b0));
      directed_rows.push_back(checked_row(8'h00, 8'hFF, 1'b1, 1'b0, 1'b1, 8'hFF, 1'b0));
      directed_rows.push_back(checked_row(BASE_N, BASE_N, 1'b0, 1'b1, 1'b1, BASE_N, 1'b1));
      directed_rows.push_back(window_row(5'd0));
      directed_rows.push_back(checked_row(BASE_G, BASE_T, 1'b0, 1'b0, 1'b1, BASE_T, 1'b0));
      directed_rows.push_back(checked_row(BASE_T, BASE_G, 1'b0, 1'b1, 1'b1, BASE_G, 1'b1));
      directed_rows.push_back(window_row(5'd16));
      directed_rows.push_back(position_row(BASE_A, BASE_C, 1'b1, 1'b0));
      directed_rows.push_back(position_row(BASE_C, BASE_A, 1'b0, 1'b0));
      directed_rows.push_back(position_row(BASE_A, BASE_A, 1'b0, 1'b1));
      directed_rows.push_back(window_row(5'd31));
      directed_rows.push_back(position_row(BASE_A, BASE_T, 1'b0, 1'b0));
      directed_rows.push_back(position_row(BASE_T, BASE_A, 1'b0, 1'b1));

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_WINDOW) set_window(directed_rows[r].window);
         else send_position(directed_rows[r]);
      end

      // Windows change without a flush, so held positions carry across.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: w = 5'd3;
            1: w = 5'd16;
            2: w = 5'd1;
            3: w = 5'd31;
            4: w = 5'd0;
            5: w = 5'd2;
            default: w = WINDOW_W'($urandom_range(1, MAX_WINDOW_DEF));
         endcase
         set_window(w);
         quiet = (phase == 2 || phase == 5);
         for (int item = 0; item < PHASE_ITEMS; item++) begin
            if (phase == 1 && item == PHASE_ITEMS / 2) drain();
            send_position(random_row());
         end
      end

      drain();
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[close_variant_window_mask.f]
rtl/core/cvwm_pkg.sv
rtl/core/cvwm_cell.sv
rtl/core/close_variant_window_mask.sv
sim/testbench.sv
